>>> design/cvd_pkg.sv
// Shared types and constants for the cumulative volume delta block.
`timescale 1ns / 1ps

package cvd_pkg;

    // Field widths
    localparam int unsigned TimeW  = 48;
    localparam int unsigned PriceW = 32;
    localparam int unsigned VolW   = 32;
    localparam int unsigned SumW   = 48;
    localparam int unsigned TfW    = 32;
    localparam int unsigned SessW  = 27;
    localparam int unsigned CfgDW  = 32;

    // Constant of the daily session mode
    localparam logic [TfW-1:0] DAY_MS = 32'd86400000;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_TIMEFRAME = 2'd0;
    localparam logic [1:0] REG_SESS_FILT = 2'd1;
    localparam logic [1:0] REG_SESS_OFS  = 2'd2;
    localparam logic [1:0] REG_SESS_LEN  = 2'd3;

    // Aggressor side codes on the input
    localparam logic [1:0] SIDE_SELL = 2'd1;
    localparam logic [1:0] SIDE_BUY  = 2'd2;

    typedef enum logic [1:0] {
        SK_PRICE,
        SK_SELL,
        SK_BUY
    } side_kind_t;

    // One classified tick as held in the front queue
    typedef struct packed {
        logic [TimeW-1:0]  trade_time;
        side_kind_t        side;
        logic [PriceW-1:0] trade_price;
        logic [VolW-1:0]   trade_volume;
        logic              close_bar;
    } tick_t;

    // Configuration register set
    typedef struct packed {
        logic [TfW-1:0]   timeframe_ms;
        logic             session_filter;
        logic [SessW-1:0] session_offset_ms;
        logic [SessW-1:0] session_length_ms;
    } cfg_t;

    // Queue head handed from front to back
    typedef struct packed {
        logic  valid;
        tick_t tick;
    } head_t;

    // Divider handshake
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [1:0] {
        ST_EVAL,
        ST_DIV,
        ST_APPLY
    } back_state_t;

endpackage

>>> design/cumulative_volume_delta_top.sv
// Top level of the cumulative volume delta block: config registers and wiring.
//
//  channel   | direction | transfer payload
//  ----------+-----------+--------------------------------------------------
//  s_t*      | in        | one trade tick per transfer
//  m_t*      | out       | one result per tick: sums and flags
//  cfg_*     | in        | register write, no read-back
//
// An item passes the back end in states evaluate and apply. A tick that opens
// a new period waits in between for the bit-serial remainder unit (48 bits).
// A two-entry queue lets the front accept while the back works; the result
// register holds under m_tready low and a new result is written as it drains.
// Reset is asynchronous, active low, and returns control state and config
// registers to their reset values; queue, divider operand and output data are not.
`timescale 1ns / 1ps

module cumulative_volume_delta_top
    import cvd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,   // trade_time[47:0], trade_price, trade_volume
    input  logic [2:0]    s_tuser,   // aggressor_side[1:0], close_bar
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata,   // delta_sum[47:0], prior_sum, closed_sum
    output logic [1:0]    m_tuser,   // closed_valid, tick_taken
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [CfgDW-1:0] cfg_wdata
);

    cfg_t              cfg_reg;
    head_t             head;
    logic              pop;
    logic              div_start;
    logic [TimeW-1:0]  div_dividend;
    logic [TfW-1:0]    div_divisor;
    div_stat_t         div_stat;
    logic [TfW-1:0]    div_rem;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeframe_ms      <= DAY_MS;
            cfg_reg.session_filter    <= 1'b0;
            cfg_reg.session_offset_ms <= '0;
            cfg_reg.session_length_ms <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TIMEFRAME: cfg_reg.timeframe_ms      <= cfg_wdata[TfW-1:0];
                REG_SESS_FILT: cfg_reg.session_filter    <= cfg_wdata[0];
                REG_SESS_OFS:  cfg_reg.session_offset_ms <= cfg_wdata[SessW-1:0];
                REG_SESS_LEN:  cfg_reg.session_length_ms <= cfg_wdata[SessW-1:0];
                default: ;
            endcase
        end
    end

    cvd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .head     (head)
    );

    cvd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    cvd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .pop          (pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_stat     (div_stat),
        .div_rem      (div_rem),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

`ifndef SYNTHESIS
    // Back end never drains an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("pop from empty queue");

    // No tick completes while the remainder unit is running
    assert property (@(posedge clk) disable iff (!rst_n) div_stat.busy |-> !pop)
        else $error("tick retired during period restart");

    // A rejected tick repeats the previous output
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[47:0] == m_tdata[95:48]))
        else $error("rejected tick changed delta_sum");

    // Without a bar close the closed sum reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[143:96] == '0))
        else $error("closed_sum nonzero without close");
`endif

endmodule

>>> design/cvd_front.sv
// Front end: accepts ticks, classifies the side and queues them (two entries).
`timescale 1ns / 1ps

module cvd_front
    import cvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [111:0]       s_tdata,  // trade_time, trade_price, trade_volume
    input  logic [2:0]         s_tuser,  // aggressor_side, close_bar
    input  logic               pop,
    output head_t              head
);

    tick_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    tick_t       in_tick;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    // Classify the incoming transfer
    always_comb
    begin
        in_tick.trade_time   = s_tdata[47:0];
        in_tick.trade_price  = s_tdata[79:48];
        in_tick.trade_volume = s_tdata[111:80];
        in_tick.close_bar    = s_tuser[2];
        case (s_tuser[1:0])
            SIDE_SELL: in_tick.side = SK_SELL;
            SIDE_BUY:  in_tick.side = SK_BUY;
            default:   in_tick.side = SK_PRICE;
        endcase
    end

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_tick;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.tick  = entry_reg[rd_ptr_reg];

endmodule

>>> design/cvd_div.sv
// Bit-serial remainder unit: timestamp modulo timeframe, one bit per cycle.
`timescale 1ns / 1ps

module cvd_div
    import cvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TimeW-1:0]  dividend,
    input  logic [TfW-1:0]    divisor,
    output div_stat_t         stat,
    output logic [TfW-1:0]    remainder
);

    localparam int unsigned CntW = $clog2(TimeW);

    logic [TimeW-1:0] num_reg, num_next;
    logic [TfW-1:0]   den_reg, den_next;
    logic [TfW-1:0]   rem_reg, rem_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [TfW:0]     trial;

    // One restoring step per cycle
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[TimeW-1]};
        if (start)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = TfW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = trial[TfW-1:0];
            end
            num_next = {num_reg[TimeW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(TimeW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

>>> design/cvd_back.sv
// Back end: period restart, session window, tick rule and saturating sum.
`timescale 1ns / 1ps

module cvd_back
    import cvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  head_t             head,
    output logic              pop,
    output logic              div_start,
    output logic [TimeW-1:0]  div_dividend,
    output logic [TfW-1:0]    div_divisor,
    input  div_stat_t         div_stat,
    input  logic [TfW-1:0]    div_rem,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [143:0]      m_tdata,  // delta_sum, prior_sum, closed_sum
    output logic [1:0]        m_tuser   // closed_valid, tick_taken
);

    localparam logic [SumW-1:0] SMax = {1'b0, {(SumW-1){1'b1}}};
    localparam logic [SumW-1:0] SMin = {1'b1, {(SumW-1){1'b0}}};

    back_state_t        state_reg, state_next;

    logic [TimeW-1:0]   open_reg, open_next;
    logic [PriceW-1:0]  last_price_reg, last_price_next;
    logic               seen_reg, seen_next;
    logic [SumW-1:0]    parked_reg, parked_next;
    logic [SumW-1:0]    sum_reg, sum_next;
    logic [SumW-1:0]    last_out_reg, last_out_next;
    logic [SumW-1:0]    closed_reg, closed_next;

    logic               out_valid_reg, out_valid_next;
    logic [143:0]       out_data_reg, out_data_next;
    logic [1:0]         out_user_reg, out_user_next;

    tick_t              tk;
    logic [TfW-1:0]     tf;
    logic               daily;
    logic [TimeW:0]     period_end;
    logic               need_new;
    logic [TimeW-1:0]   floor_t;
    logic [TimeW:0]     open_sum;
    logic [TfW-1:0]     win_len;
    logic [TimeW:0]     win_end;
    logic               taken;
    logic               out_free;
    logic [TimeW:0]     park_sum;
    logic               use_parked;
    logic               neg;
    logic               adds;
    logic [SumW+1:0]    mag;
    logic [SumW+1:0]    sum_wide;

    assign tk         = head.tick;
    assign tf         = (cfg.timeframe_ms == '0) ? TfW'(1) : cfg.timeframe_ms;
    assign daily      = cfg.session_filter && (tf == DAY_MS);
    assign period_end = {1'b0, open_reg} + {{(TimeW+1-TfW){1'b0}}, tf};
    assign need_new   = ({1'b0, tk.trade_time} > period_end);
    assign out_free   = !out_valid_reg || m_tready;

    // New open time: floor to timeframe, session offset, clamp
    assign floor_t  = tk.trade_time - {{(TimeW-TfW){1'b0}}, div_rem};
    assign open_sum = {1'b0, floor_t}
                    + (daily ? {{(TimeW+1-SessW){1'b0}}, cfg.session_offset_ms}
                             : '0);

    // Session window
    assign win_len = (cfg.session_length_ms == '0) ? tf
                   : {{(TfW-SessW){1'b0}}, cfg.session_length_ms};
    assign win_end = {1'b0, open_reg} + {{(TimeW+1-TfW){1'b0}}, win_len};
    assign taken   = !daily
                   || (!(tk.trade_time < open_reg)
                       && ({1'b0, tk.trade_time} < win_end));

    // Tick rule decision
    always_comb
    begin
        use_parked = 1'b0;
        neg        = 1'b0;
        adds       = 1'b1;
        case (tk.side)
            SK_SELL: neg = 1'b1;
            SK_BUY:  neg = 1'b0;
            default:
            begin
                if (!seen_reg || tk.trade_price == last_price_reg)
                begin
                    adds = 1'b0;
                end
                else
                begin
                    use_parked = 1'b1;
                    neg        = (tk.trade_price < last_price_reg);
                end
            end
        endcase
    end

    assign park_sum = {1'b0, parked_reg} + {{(TimeW+1-VolW){1'b0}}, tk.trade_volume};
    assign mag      = {{(SumW+2-VolW){1'b0}}, tk.trade_volume}
                    + (use_parked ? {2'b00, parked_reg} : '0);
    assign sum_wide = {{2{sum_reg[SumW-1]}}, sum_reg}
                    + (adds ? (neg ? (~mag + 1'b1) : mag) : '0);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        open_next       = open_reg;
        last_price_next = last_price_reg;
        seen_next       = seen_reg;
        parked_next     = parked_reg;
        sum_next        = sum_reg;
        last_out_next   = last_out_reg;
        closed_next     = closed_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        pop             = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_EVAL:
            begin
                if (head.valid)
                begin
                    closed_next = tk.close_bar ? sum_reg : '0;
                    if (need_new)
                    begin
                        div_start  = 1'b1;
                        sum_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    open_next  = open_sum[TimeW] ? {TimeW{1'b1}} : open_sum[TimeW-1:0];
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    pop           = 1'b1;
                    state_next    = ST_EVAL;
                    last_out_next = last_out_reg;
                    if (taken)
                    begin
                        last_price_next = tk.trade_price;
                        seen_next       = 1'b1;
                        if (use_parked)
                        begin
                            parked_next = '0;
                        end
                        else if (tk.side == SK_PRICE && seen_reg)
                        begin
                            parked_next = park_sum[TimeW] ? {SumW{1'b1}}
                                                          : park_sum[SumW-1:0];
                        end
                        if ($signed(sum_wide) > $signed({2'b00, SMax}))
                        begin
                            sum_next = SMax;
                        end
                        else if ($signed(sum_wide) < $signed({2'b11, SMin}))
                        begin
                            sum_next = SMin;
                        end
                        else
                        begin
                            sum_next = sum_wide[SumW-1:0];
                        end
                        last_out_next = sum_next;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {closed_reg, last_out_reg, last_out_next};
                    out_user_next  = {taken, tk.close_bar};
                end
            end
            default:
            begin
                state_next = ST_EVAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EVAL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= '0;
            last_price_reg <= '0;
            seen_reg       <= 1'b0;
            parked_reg     <= '0;
            sum_reg        <= '0;
            last_out_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            open_reg       <= open_next;
            last_price_reg <= last_price_next;
            seen_reg       <= seen_next;
            parked_reg     <= parked_next;
            sum_reg        <= sum_next;
            last_out_reg   <= last_out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        closed_reg   <= closed_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign div_dividend = tk.trade_time;
    assign div_divisor  = tf;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tuser      = out_user_reg;

endmodule
